// ===== rtl/utf8_string_transcoder_macros.svh =====
// ----------------------------------------------------------------------------
// utf8 string transcoder assertion macros
// concurrent assertion helpers shared by the transcoder rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_STRING_TRANSCODER_MACROS_SVH
`define UTF8_STRING_TRANSCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define UTF8ST_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("utf8st assertion failed");
`define UTF8ST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("utf8st implication failed");
`else
`define UTF8ST_ASSERT(lbl, clk, rst_n, expr)
`define UTF8ST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/utf8st_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8st_pkg
// types and constants shared by the utf8 string transcoder
// ----------------------------------------------------------------------------
package utf8st_pkg;

	localparam int MAX_RES = 5;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);
	localparam int UNIT_W  = 21;

	localparam logic [1:0] ENC_UTF8  = 2'd0;
	localparam logic [1:0] ENC_UTF16 = 2'd1;

	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	localparam logic [UNIT_W-1:0] MIN_3B  = 21'h000800;
	localparam logic [UNIT_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [UNIT_W-1:0] SURR_HI = 21'h00DFFF;
	localparam logic [UNIT_W-1:0] MIN_4B  = 21'h010000;
	localparam logic [UNIT_W-1:0] CP_MAX  = 21'h10FFFF;
	localparam logic [15:0]       HI_SURR_BASE = 16'hD800;
	localparam logic [15:0]       LO_SURR_BASE = 16'hDC00;

	typedef struct packed {
		logic [UNIT_W-1:0] code;
		logic              err;
		logic              last;
	} unit_t;

	typedef struct packed {
		unit_t [MAX_RES-1:0] ents;
		logic [CNT_W-1:0]    cnt;
	} res_list_t;

endpackage

// ===== rtl/utf8st_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8st_decoder
// strict utf-8 decode state and per-beat result list generation
// ----------------------------------------------------------------------------
`include "utf8_string_transcoder_macros.svh"

module utf8st_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            in_byte,
	input  logic                  byte_present,
	input  logic                  end_of_string,
	input  logic [1:0]            enc_q,
	output utf8st_pkg::res_list_t res
);
	import utf8st_pkg::*;

	logic [UNIT_W-1:0] pp_q, pp_n, acc, cp;
	logic [1:0]        br_q, br_n, sl_q, sl_n;
	logic              skip_q, skip_n;
	logic              have_cp, byte_fail, bad;
	logic [UNIT_W-1:0] v;
	unit_t [3:0]       pu;
	logic [2:0]        pn;

	always_comb begin
		pp_n      = pp_q;
		br_n      = br_q;
		sl_n      = sl_q;
		skip_n    = skip_q;
		have_cp   = 1'b0;
		byte_fail = 1'b0;
		bad       = 1'b0;
		cp        = '0;
		acc       = {pp_q[UNIT_W-7:0], in_byte[5:0]};
		if (byte_present && !skip_q) begin
			if (br_q == 2'd0) begin
				priority if (in_byte[7] == 1'b0) begin
					have_cp = 1'b1;
					cp      = {13'b0, in_byte};
				end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
					pp_n = {16'b0, in_byte[4:0]};
					br_n = 2'd1;
					sl_n = 2'd1;
				end else if (in_byte[7:4] == 4'hE) begin
					pp_n = {17'b0, in_byte[3:0]};
					br_n = 2'd2;
					sl_n = 2'd2;
				end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
					pp_n = {18'b0, in_byte[2:0]};
					br_n = 2'd3;
					sl_n = 2'd3;
				end else begin
					byte_fail = 1'b1;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				byte_fail = 1'b1;
			end else begin
				br_n = br_q - 2'd1;
				if (br_n != 2'd0) begin
					pp_n = acc;
				end else begin
					if (sl_q == 2'd2)
						bad = (acc < MIN_3B) || (acc >= SURR_LO && acc <= SURR_HI);
					else if (sl_q == 2'd3)
						bad = (acc < MIN_4B) || (acc > CP_MAX);
					if (bad) begin
						byte_fail = 1'b1;
					end else begin
						have_cp = 1'b1;
						cp      = acc;
						pp_n    = '0;
						sl_n    = 2'd0;
					end
				end
			end
		end
		if (byte_fail) begin
			pp_n   = '0;
			br_n   = 2'd0;
			sl_n   = 2'd0;
			skip_n = 1'b1;
		end
	end

	// code point to output units
	always_comb begin
		pu = '0;
		pn = 3'd0;
		v  = cp - MIN_4B;
		if (have_cp) begin
			unique case (enc_q)
				ENC_UTF8: begin
					if (cp <= 21'h7F) begin
						pu[0].code = cp;
						pn = 3'd1;
					end else if (cp <= 21'h7FF) begin
						pu[0].code = {13'b0, 3'b110, cp[10:6]};
						pu[1].code = {13'b0, 2'b10, cp[5:0]};
						pn = 3'd2;
					end else if (cp <= 21'hFFFF) begin
						pu[0].code = {13'b0, 4'hE, cp[15:12]};
						pu[1].code = {13'b0, 2'b10, cp[11:6]};
						pu[2].code = {13'b0, 2'b10, cp[5:0]};
						pn = 3'd3;
					end else begin
						pu[0].code = {13'b0, 5'b11110, cp[20:18]};
						pu[1].code = {13'b0, 2'b10, cp[17:12]};
						pu[2].code = {13'b0, 2'b10, cp[11:6]};
						pu[3].code = {13'b0, 2'b10, cp[5:0]};
						pn = 3'd4;
					end
				end
				ENC_UTF16: begin
					if (cp <= 21'hFFFF) begin
						pu[0].code = cp;
						pn = 3'd1;
					end else begin
						pu[0].code = {5'b0, HI_SURR_BASE + {6'b0, v[19:10]}};
						pu[1].code = {5'b0, LO_SURR_BASE + {6'b0, v[9:0]}};
						pn = 3'd2;
					end
				end
				default: begin
					pu[0].code = cp;
					pn = 3'd1;
				end
			endcase
		end
	end

	// result list: error alone, or units then a terminator at end of string
	always_comb begin
		res = '0;
		if (byte_fail) begin
			res.ents[0].err  = 1'b1;
			res.ents[0].last = 1'b1;
			res.cnt = CNT_W'(1);
		end else begin
			for (int i = 0; i < 4; i++)
				res.ents[i] = pu[i];
			res.cnt = CNT_W'(pn);
			if (end_of_string && !skip_q) begin
				for (int i = 0; i < MAX_RES; i++) begin
					if (i == int'(pn)) begin
						res.ents[i].code = '0;
						res.ents[i].err  = (br_n != 2'd0);
						res.ents[i].last = 1'b1;
					end
				end
				res.cnt = CNT_W'(pn) + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q   <= '0;
			br_q   <= 2'd0;
			sl_q   <= 2'd0;
			skip_q <= 1'b0;
		end else if (take) begin
			if (end_of_string) begin
				pp_q   <= '0;
				br_q   <= 2'd0;
				sl_q   <= 2'd0;
				skip_q <= 1'b0;
			end else begin
				pp_q   <= pp_n;
				br_q   <= br_n;
				sl_q   <= sl_n;
				skip_q <= skip_n;
			end
		end
	end

	`UTF8ST_ASSERT_IMP(a_skip_clean, clk, arst_n, skip_q, (br_q == 2'd0) && (pp_q == '0))
	`UTF8ST_ASSERT(a_br_le_sl, clk, arst_n, br_q <= sl_q)
	`UTF8ST_ASSERT_IMP(a_fail_single, clk, arst_n, take && byte_fail, res.cnt == CNT_W'(1))

endmodule

// ===== rtl/utf8st_out_buf.sv =====
// ----------------------------------------------------------------------------
// utf8st_out_buf
// result register holding one beat's result list, drained one unit a cycle while m_tready is high
// ----------------------------------------------------------------------------
`include "utf8_string_transcoder_macros.svh"

module utf8st_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  utf8st_pkg::res_list_t res,
	output logic                  can_take,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output utf8st_pkg::unit_t     head
);
	import utf8st_pkg::*;

	unit_t [MAX_RES-1:0] ents_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic                pop;

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign can_take = (cnt_q == '0) || (cnt_q == CNT_W'(1) && m_tready);
	assign head     = ents_q[idx_q];

	always_ff @(posedge clk) begin
		if (load && res.cnt != '0)
			ents_q <= res.ents;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
			idx_q <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	`UTF8ST_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(MAX_RES))
	`UTF8ST_ASSERT_IMP(a_last_final, clk, arst_n, m_tvalid && head.last, cnt_q == CNT_W'(1))
	`UTF8ST_ASSERT_IMP(a_load_drained, clk, arst_n, load && m_tvalid,
		pop && cnt_q == CNT_W'(1))

endmodule

// ===== rtl/utf8_string_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_string_transcoder
// strict utf-8 decoder re-emitting code points as utf-8, utf-16 or utf-32
// ----------------------------------------------------------------------------
// input beats on s_*: one raw byte per beat, s_tuser marks the byte as
// present, s_tlast ends the string. output beats on m_*: one code unit per
// beat, m_tuser flags the error result, m_tlast marks the zero terminator
// or the error result of a string. cfg_we/cfg_wdata set the output form
// (0 utf-8, 1 utf-16, 2 or 3 utf-32) and must be written only while idle;
// the block does not enforce this. a beat is decoded in the cycle it is
// accepted; its results appear in the result register in the next cycle
// and leave one unit per cycle while m_tready is high. throughput: one
// input beat per cycle while each beat yields at most one unit; a beat
// that yields n units (up to 5) holds s_tready low while they drain.
// a stalled m_tready holds the current unit and, once the last unit of the
// list is waiting, blocks new input beats.
// reset clears the decode state, empties the result register and selects
// utf-8 output.
// ----------------------------------------------------------------------------
module utf8_string_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // in_byte
	input  logic        s_tuser,  // byte_present
	input  logic        s_tlast,  // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // code_unit, zero fill
	output logic        m_tuser,  // error
	output logic        m_tlast   // last
);
	import utf8st_pkg::*;

	logic      [1:0] enc_q;
	logic            take;
	res_list_t       res;
	unit_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			enc_q <= ENC_UTF8;
		else if (cfg_we)
			enc_q <= cfg_wdata;
	end

	assign take = s_tvalid && s_tready;

	utf8st_decoder u_dec (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.in_byte       (s_tdata),
		.byte_present  (s_tuser),
		.end_of_string (s_tlast),
		.enc_q         (enc_q),
		.res           (res)
	);

	utf8st_out_buf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.res      (res),
		.can_take (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {3'b0, head.code};
	assign m_tuser = head.err;
	assign m_tlast = head.last;

endmodule

// ===== tb/tb_utf8_string_transcoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_string_transcoder
// stream-level check of the strict utf-8 decoder and its three output forms.
// a queue-fed driver sends byte beats with random gaps, the receiver stalls
// at random, and a monitor decodes every accepted input beat with its own
// copy of the decoder state to predict the code units, comparing each
// output beat in order. a directed string set is followed by random strings,
// mostly well-formed, with broken, truncated and out-of-range sequences mixed
// in, under every output encoding setting.
// ----------------------------------------------------------------------------
module tb_utf8_string_transcoder;
	import utf8st_pkg::*;

	localparam logic [1:0] ENC_UTF32 = 2'd2;
	localparam logic [1:0] ENC_SPARE = 2'd3;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam int RAND_PHASES     = 9;
	localparam int BEATS_PER_PHASE = 38;
	localparam int TAIL_CYCLES     = 8;
	localparam int REPORT_CAP      = 30;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eos;
	} in_beat_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        s_tuser   = 1'b0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	utf8_string_transcoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	in_beat_t    beats_pending[$];
	unit_t       units_due[$];
	logic [7:0]  text_bytes[$];

	int beats_queued   = 0;
	int beats_taken    = 0;
	int phase_beats    = 0;
	int strings_done   = 0;
	int units_seen     = 0;
	int error_units    = 0;
	int settings_used  = 0;
	int mismatches     = 0;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	bit in_beat_taken  = 1'b0;

	// decoder copy
	logic [1:0]  enc_sel    = ENC_UTF8;
	logic [20:0] cp_acc     = '0;
	logic [1:0]  cont_left  = '0;
	logic [1:0]  cont_total = '0;
	logic        skip_rest  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[utf8_string_transcoder] ERROR");
		$finish;
	end

	task automatic push_unit(input logic [20:0] code, input logic err, input logic last);
		unit_t u;
		u.code = code;
		u.err  = err;
		u.last = last;
		units_due.insert(units_due.size(), u);
	endtask

	task automatic encode_point(input logic [20:0] cp);
		logic [20:0] v;
		case (enc_sel)
			ENC_UTF8: begin
				if (cp <= 21'h7F) begin
					push_unit(cp, 1'b0, 1'b0);
				end else if (cp <= 21'h7FF) begin
					push_unit(21'({3'b110, cp[10:6]}), 1'b0, 1'b0);
					push_unit(21'({2'b10, cp[5:0]}), 1'b0, 1'b0);
				end else if (cp <= 21'hFFFF) begin
					push_unit(21'({4'b1110, cp[15:12]}), 1'b0, 1'b0);
					push_unit(21'({2'b10, cp[11:6]}), 1'b0, 1'b0);
					push_unit(21'({2'b10, cp[5:0]}), 1'b0, 1'b0);
				end else begin
					push_unit(21'({5'b11110, cp[20:18]}), 1'b0, 1'b0);
					push_unit(21'({2'b10, cp[17:12]}), 1'b0, 1'b0);
					push_unit(21'({2'b10, cp[11:6]}), 1'b0, 1'b0);
					push_unit(21'({2'b10, cp[5:0]}), 1'b0, 1'b0);
				end
			end
			ENC_UTF16: begin
				if (cp <= 21'hFFFF) begin
					push_unit(cp, 1'b0, 1'b0);
				end else begin
					v = cp - MIN_4B;
					push_unit(21'(HI_SURR_BASE) + 21'(v[19:10]), 1'b0, 1'b0);
					push_unit(21'(LO_SURR_BASE) + 21'(v[9:0]), 1'b0, 1'b0);
				end
			end
			default: begin
				push_unit(cp, 1'b0, 1'b0);
			end
		endcase
	endtask

	task automatic raise_error();
		push_unit('0, 1'b1, 1'b1);
		skip_rest  = 1'b1;
		cp_acc     = '0;
		cont_left  = '0;
		cont_total = '0;
	endtask

	task automatic decode_byte(input logic [7:0] c);
		logic        bad;
		logic [20:0] cp;
		if (cont_left == 2'd0) begin
			if (c <= 8'h7F) begin
				encode_point(21'(c));
			end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
				cp_acc     = 21'(c[4:0]);
				cont_left  = 2'd1;
				cont_total = 2'd1;
			end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
				cp_acc     = 21'(c[3:0]);
				cont_left  = 2'd2;
				cont_total = 2'd2;
			end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
				cp_acc     = 21'(c[2:0]);
				cont_left  = 2'd3;
				cont_total = 2'd3;
			end else begin
				raise_error();
			end
		end else if (c[7:6] != 2'b10) begin
			raise_error();
		end else begin
			cp_acc    = {cp_acc[14:0], c[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				bad = 1'b0;
				if (cont_total == 2'd2)
					bad = cp_acc < MIN_3B || (cp_acc >= SURR_LO && cp_acc <= SURR_HI);
				else if (cont_total == 2'd3)
					bad = cp_acc < MIN_4B || cp_acc > CP_MAX;
				if (bad) begin
					raise_error();
				end else begin
					cp         = cp_acc;
					cp_acc     = '0;
					cont_total = '0;
					encode_point(cp);
				end
			end
		end
	endtask

	task automatic decode_beat(input logic [7:0] data, input logic present, input logic eos);
		if (present && !skip_rest)
			decode_byte(data);
		if (eos) begin
			if (!skip_rest)
				push_unit('0, cont_left != 2'd0, 1'b1);
			cp_acc     = '0;
			cont_left  = '0;
			cont_total = '0;
			skip_rest  = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [23:0] want,
			input logic [23:0] got);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
	endtask

	// input valid and output ready held low in reset, then one beat per handshake
	always @(negedge clk) begin : send_recv
		in_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || in_beat_taken) begin
				if (beats_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					nxt = beats_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data;
					s_tuser  <= nxt.present;
					s_tlast  <= nxt.eos;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin : observe
		unit_t want;
		if (!arst_n) begin
			in_beat_taken = 1'b0;
		end else begin
			in_beat_taken = s_tvalid && s_tready;
			if (in_beat_taken) begin
				beats_taken++;
				if (s_tlast)
					strings_done++;
				decode_beat(s_tdata, s_tuser, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				units_seen++;
				if (m_tuser)
					error_units++;
				if (units_due.size() == 0) begin
					report_mismatch("unexpected beat", '0, {m_tuser, m_tlast, 1'b0, m_tdata[20:0]});
				end else begin
					want = units_due.pop_front();
					if (m_tdata !== {3'b000, want.code})
						report_mismatch("code_unit", {3'b000, want.code}, m_tdata);
					if (m_tuser !== want.err)
						report_mismatch("error", 24'(want.err), 24'(m_tuser));
					if (m_tlast !== want.last)
						report_mismatch("last", 24'(want.last), 24'(m_tlast));
				end
			end
		end
	end

	task automatic queue_beat(input logic [7:0] data, input logic present, input logic eos);
		in_beat_t b;
		b.data    = data;
		b.present = present;
		b.eos     = eos;
		beats_pending.insert(beats_pending.size(), b);
		beats_queued++;
		if (present || eos)
			phase_beats++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endtask

	task automatic add_utf8(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			add_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp <= 21'hFFFF) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endtask

	task automatic add_random_point();
		logic [20:0] cp;
		case ($urandom_range(0, 4))
			0: cp = 21'($urandom_range(0, 'h7F));
			1: cp = 21'($urandom_range('h80, 'h7FF));
			2: cp = $urandom_range(0, 1) ? 21'($urandom_range('h800, 'hD7FF))
				: 21'($urandom_range('hE000, 'hFFFF));
			3: cp = 21'($urandom_range('h10000, 'h10FFFF));
			default: begin
				case ($urandom_range(0, 9))
					0: cp = 21'h0;
					1: cp = 21'h7F;
					2: cp = 21'h80;
					3: cp = 21'h7FF;
					4: cp = 21'h800;
					5: cp = 21'hD7FF;
					6: cp = 21'hE000;
					7: cp = 21'hFFFF;
					8: cp = 21'h10000;
					default: cp = 21'h10FFFF;
				endcase
			end
		endcase
		add_utf8(cp);
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range('h80, 'hBF));
	endfunction

	// broken sequences; cut is set when the string has to end right here
	task automatic add_broken(output bit cut);
		int depth;
		cut = 1'b0;
		case ($urandom_range(0, 7))
			0: add_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
				: 8'($urandom_range('hF5, 'hFF)));
			1: begin
				add_byte(8'hE0);
				add_byte(8'($urandom_range('h80, 'h9F)));
				add_byte(cont_byte());
			end
			2: begin
				add_byte(8'hED);
				add_byte(8'($urandom_range('hA0, 'hBF)));
				add_byte(cont_byte());
			end
			3: begin
				add_byte(8'hF4);
				add_byte(8'($urandom_range('h90, 'hBF)));
				add_byte(cont_byte());
				add_byte(cont_byte());
			end
			4: begin
				add_byte(8'hF0);
				add_byte(8'($urandom_range('h80, 'h8F)));
				add_byte(cont_byte());
				add_byte(cont_byte());
			end
			5, 6: begin
				depth = $urandom_range(1, 3);
				case (depth)
					1: add_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
					2: add_byte(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
					default: add_byte(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
				endcase
				repeat ($urandom_range(0, depth - 1))
					add_byte(cont_byte());
				if ($urandom_range(0, 1))
					add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
						: 8'($urandom_range('hC0, 'hFF)));
				else
					cut = 1'b1;
			end
			default: add_byte(8'($urandom));
		endcase
	endtask

	task automatic queue_string();
		int  n;
		int  brk;
		bit  broken;
		bit  cut;
		bit  end_on_byte;
		text_bytes.delete();
		n           = $urandom_range(0, 6);
		broken      = $urandom_range(0, 99) < 30;
		brk         = $urandom_range(0, n);
		cut         = 1'b0;
		end_on_byte = $urandom_range(0, 1);
		for (int i = 0; i <= n && !cut; i++) begin
			if (broken && i == brk)
				add_broken(cut);
			else if (i < n)
				add_random_point();
		end
		for (int i = 0; i < text_bytes.size(); i++) begin
			if ($urandom_range(0, 99) < 5)
				queue_beat(8'($urandom), 1'b0, 1'b0);
			queue_beat(text_bytes[i], 1'b1, end_on_byte && i == text_bytes.size() - 1);
		end
		if (!end_on_byte || text_bytes.size() == 0)
			queue_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (beats_taken != beats_queued || units_due.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_encoding(input logic [1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		enc_sel    = val;
		settings_used++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [1:0] plan_encoding(input int ph);
		case (ph % 5)
			0: return ENC_UTF16;
			1: return ENC_UTF32;
			2: return ENC_SPARE;
			3: return ENC_UTF8;
			default: return ENC_UTF16;
		endcase
	endfunction

	task automatic set_idling(input int ph);
		case (ph * 3 / RAND_PHASES)
			0: begin
				send_gap_pct   = 13;
				recv_stall_pct = 50;
			end
			1: begin
				send_gap_pct   = 50;
				recv_stall_pct = 13;
			end
			default: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		set_idling(0);
		write_encoding(ENC_UTF8);
		@(posedge clk);
		// range extremes of each sequence length
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'h7F, 1'b1, 1'b0);
		queue_beat(8'hDF, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b0);
		queue_beat(8'hEF, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b0);
		queue_beat(8'hF4, 1'b1, 1'b0);
		queue_beat(8'h8F, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b1);
		// empty beat
		queue_beat(8'hFF, 1'b0, 1'b0);
		// surrogate, then end-only beat while skipping
		queue_beat(8'hED, 1'b1, 1'b0);
		queue_beat(8'hA0, 1'b1, 1'b0);
		queue_beat(8'h80, 1'b1, 1'b0);
		queue_beat(8'h5A, 1'b0, 1'b1);
		// overlong three-byte form ending the string
		queue_beat(8'hE0, 1'b1, 1'b0);
		queue_beat(8'h9F, 1'b1, 1'b0);
		queue_beat(8'hBF, 1'b1, 1'b1);
		// above the code point range
		queue_beat(8'hF4, 1'b1, 1'b0);
		queue_beat(8'h90, 1'b1, 1'b0);
		queue_beat(8'h80, 1'b1, 1'b0);
		queue_beat(8'h80, 1'b1, 1'b1);
		// bad lead, missing continuation, truncated sequence
		queue_beat(8'hC1, 1'b1, 1'b1);
		queue_beat(8'hC2, 1'b1, 1'b0);
		queue_beat(8'h41, 1'b1, 1'b1);
		queue_beat(8'hF0, 1'b1, 1'b1);
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_idling(ph);
			write_encoding(plan_encoding(ph));
			@(posedge clk);
			phase_beats = 0;
			while (phase_beats < BEATS_PER_PHASE)
				queue_string();
			wait_drained();
		end

		$display("sent %0d input beats in %0d strings over %0d encoding writes",
			beats_taken, strings_done, settings_used);
		$display("checked %0d output beats, %0d of them error results, %0d mismatches",
			units_seen, error_units, mismatches);
		if (mismatches == 0)
			$display("[utf8_string_transcoder] OK");
		else
			$display("[utf8_string_transcoder] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/utf8st_pkg.sv
rtl/utf8st_decoder.sv
rtl/utf8st_out_buf.sv
rtl/utf8_string_transcoder.sv
tb/tb_utf8_string_transcoder.sv
